### rtl/rdse_pkg.sv
// Package for the radix digit string emitter: widths, character constants,
// the digit-to-character mapping and the structs passed between modules.
// Depends on nothing; every other file of the block uses it.
package rdse_pkg;

  // Fixed port widths.
  localparam int VALUE_IN_W = 64;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;

  // Number of low value bits that take part in the conversion (8 to 64).
  localparam int VALUE_WIDTH = 64;

  // A digit is below the largest base, so it fits the base width.
  localparam int DIGIT_W     = RADIX_W;
  // At most one digit per value bit, reached in base two.
  localparam int DIGIT_DEPTH = VALUE_WIDTH;
  localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
  // Bit counter of the divider, holds VALUE_WIDTH itself.
  localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(62);

  localparam logic [DIGIT_W-1:0] DIGIT_FIRST_UPPER = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_FIRST_LOWER = DIGIT_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(8'h30);  // '0'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = CHAR_W'(8'h41);  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(8'h61);  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_NONE    = '0;

  typedef logic [VALUE_WIDTH-1:0] num_t;
  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [DIGIT_AW-1:0]    digit_addr_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                 start;
    num_t                 dividend;
    logic [RADIX_W-1:0]   divisor;
  } div_req_t;

  // Response of the shared divider; quotient and remainder hold until next start.
  typedef struct packed {
    logic   done;
    num_t   quotient;
    digit_t remainder;
  } div_rsp_t;

  // Write port of the digit store.
  typedef struct packed {
    logic        en;
    digit_addr_t addr;
    digit_t      data;
  } digit_wr_t;

  // Digits 0-9 map to '0'-'9', 10-35 to 'A'-'Z' and 36-61 to 'a'-'z'.
  function automatic logic [CHAR_W-1:0] digit_to_char(input digit_t d);
    logic [CHAR_W-1:0] d_ext;
    logic [CHAR_W-1:0] ch;
    d_ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d < DIGIT_FIRST_UPPER) begin
      ch = CHAR_ZERO + d_ext;
    end else if (d < DIGIT_FIRST_LOWER) begin
      ch = CHAR_UPPER_A + d_ext - {{(CHAR_W - DIGIT_W){1'b0}}, DIGIT_FIRST_UPPER};
    end else begin
      ch = CHAR_LOWER_A + d_ext - {{(CHAR_W - DIGIT_W){1'b0}}, DIGIT_FIRST_LOWER};
    end
    return ch;
  endfunction

endpackage

### rtl/rdse_if.sv
// Valid/ready channel interfaces of the radix digit string emitter.
// Depends on rdse_pkg for the payload widths.
interface rdse_in_if;
  logic                          valid;
  logic                          ready;
  logic [rdse_pkg::VALUE_IN_W-1:0] value;
  logic [rdse_pkg::RADIX_W-1:0]  radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink (input valid, input value, input radix, output ready);
endinterface

interface rdse_out_if;
  logic                        valid;
  logic                        ready;
  logic [rdse_pkg::CHAR_W-1:0] digit_char;
  logic                        last;
  logic                        bad_radix;

  modport source (output valid, output digit_char, output last, output bad_radix, input ready);
  modport sink (input valid, input digit_char, input last, input bad_radix, output ready);
endinterface

### rtl/rdse_divider.sv
// Shared restoring divider: divides a value by a small base, one quotient
// bit per cycle. Depends on rdse_pkg.
module rdse_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdse_pkg::div_req_t req_i,
  output rdse_pkg::div_rsp_t rsp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [rdse_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  rdse_pkg::num_t                    quo_q, quo_d;
  rdse_pkg::digit_t                  rem_q, rem_d;
  logic [rdse_pkg::RADIX_W-1:0]      div_q, div_d;
  logic [rdse_pkg::DIGIT_W:0]        trial;
  logic                              fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {rem_q, quo_q[rdse_pkg::VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = rdse_pkg::DIV_CNT_W'(rdse_pkg::VALUE_WIDTH);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[rdse_pkg::VALUE_WIDTH-2:0], fits};
      rem_d = fits ? rdse_pkg::DIGIT_W'(trial - {1'b0, div_q})
                   : trial[rdse_pkg::DIGIT_W-1:0];
      cnt_d = cnt_q - rdse_pkg::DIV_CNT_W'(1);
      if (cnt_q == rdse_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### rtl/rdse_digit_store.sv
// Digit store: holds the digits of one number, least significant at address
// zero. One write and one registered read per cycle. Depends on rdse_pkg.
module rdse_digit_store (
  input  logic                  clk_i,
  input  rdse_pkg::digit_wr_t   wr_i,
  input  logic                  rd_en_i,
  input  rdse_pkg::digit_addr_t rd_addr_i,
  output rdse_pkg::digit_t      rd_data_o
);

  rdse_pkg::digit_t mem_q [rdse_pkg::DIGIT_DEPTH];
  rdse_pkg::digit_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/radix_digit_string_emitter_unit.sv
// Radix digit string emitter, top level. Each digit of an item is divided
// out in turn, one divider bit per cycle; the digits are then emitted through
// the read, load and emit states, plus output stalls. Base 2 of a full 64-bit
// value is the slowest case. A bad base or a zero value gives its single
// result the cycle after the item is taken. Reset is asynchronous, active
// low, and returns the sequencer to idle with no result.
module radix_digit_string_emitter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdse_in_if.sink     in_i,
  rdse_out_if.source  out_o
);

  // The sequencer walks each item through its phases; only one item is
  // in flight, so input ready is simply the idle state.
  typedef enum logic [2:0] {
    StIdle,
    StDivStart,
    StDivWait,
    StRead,
    StLoad,
    StEmit
  } state_e;

  state_e                       state_q, state_d;
  logic                         out_valid_q, out_valid_d;
  rdse_pkg::digit_addr_t        wr_ptr_q, wr_ptr_d;
  rdse_pkg::digit_addr_t        rd_ptr_q, rd_ptr_d;

  // Payload registers, no reset needed.
  rdse_pkg::num_t               num_q, num_d;
  logic [rdse_pkg::RADIX_W-1:0] radix_q, radix_d;
  logic [rdse_pkg::CHAR_W-1:0]  char_q, char_d;
  logic                         last_q, last_d;
  logic                         bad_q, bad_d;

  rdse_pkg::div_req_t           div_req;
  rdse_pkg::div_rsp_t           div_rsp;
  rdse_pkg::digit_wr_t          store_wr;
  logic                         store_rd_en;
  rdse_pkg::digit_t             store_rd_data;

  logic                         in_fire;
  logic                         out_fire;
  logic                         radix_bad;
  rdse_pkg::num_t               in_num;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_o.valid && out_o.ready;
  // Only the low VALUE_WIDTH bits of the input value count.
  assign in_num    = in_i.value[rdse_pkg::VALUE_WIDTH-1:0];
  assign radix_bad = (in_i.radix < rdse_pkg::RADIX_MIN) ||
                     (in_i.radix > rdse_pkg::RADIX_MAX);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    num_d       = num_q;
    radix_d     = radix_q;
    char_d      = char_q;
    last_d      = last_q;
    bad_d       = bad_q;

    div_req.start    = 1'b0;
    div_req.dividend = num_q;
    div_req.divisor  = radix_q;

    store_wr.en   = 1'b0;
    store_wr.addr = wr_ptr_q;
    store_wr.data = div_rsp.remainder;
    store_rd_en   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (radix_bad) begin
            // A bad base gives one flagged result with no character.
            char_d      = rdse_pkg::CHAR_NONE;
            last_d      = 1'b1;
            bad_d       = 1'b1;
            out_valid_d = 1'b1;
            state_d     = StEmit;
          end else if (in_num == '0) begin
            // Zero is written as the single digit '0'.
            char_d      = rdse_pkg::CHAR_ZERO;
            last_d      = 1'b1;
            bad_d       = 1'b0;
            out_valid_d = 1'b1;
            state_d     = StEmit;
          end else begin
            num_d    = in_num;
            radix_d  = in_i.radix;
            wr_ptr_d = '0;
            state_d  = StDivStart;
          end
        end
      end

      StDivStart: begin
        div_req.start = 1'b1;
        state_d       = StDivWait;
      end

      StDivWait: begin
        if (div_rsp.done) begin
          // Remainders come out least significant first; store them in
          // order and read them back from the top.
          store_wr.en = 1'b1;
          if (div_rsp.quotient == '0) begin
            rd_ptr_d = wr_ptr_q;
            state_d  = StRead;
          end else begin
            num_d    = div_rsp.quotient;
            wr_ptr_d = wr_ptr_q + rdse_pkg::DIGIT_AW'(1);
            state_d  = StDivStart;
          end
        end
      end

      StRead: begin
        store_rd_en = 1'b1;
        state_d     = StLoad;
      end

      StLoad: begin
        char_d      = rdse_pkg::digit_to_char(store_rd_data);
        last_d      = (rd_ptr_q == '0);
        bad_d       = 1'b0;
        out_valid_d = 1'b1;
        state_d     = StEmit;
      end

      StEmit: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = StIdle;
          end else begin
            rd_ptr_d = rd_ptr_q - rdse_pkg::DIGIT_AW'(1);
            state_d  = StRead;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    radix_q <= radix_d;
    char_q  <= char_d;
    last_q  <= last_d;
    bad_q   <= bad_d;
  end

  rdse_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rdse_digit_store u_digit_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_en_i   (store_rd_en),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (store_rd_data)
  );

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = out_valid_q;
  assign out_o.digit_char  = char_q;
  assign out_o.last        = last_q;
  assign out_o.bad_radix   = bad_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_digit_string_emitter_unit: directed and random numbers,
// each predicted digit by digit and checked against the emitted character stream.
// Depends on rdse_pkg and the rdse_in_if / rdse_out_if channel interfaces of the RTL.
module testbench;

  localparam int VW = rdse_pkg::VALUE_IN_W;
  localparam int RW = rdse_pkg::RADIX_W;
  localparam int CW = rdse_pkg::CHAR_W;

  // Pause after the last expected character, to catch stray extra characters.
  localparam int SETTLE_CYCLES    = 300;
  // Receiver hold-off used to back the block up into its input.
  localparam int BACKUP_STALL     = 3000;
  localparam int MAX_PRINTED_ERRS = 40;

  typedef struct {
    logic [CW-1:0] digit_char;
    logic          last;
    logic          bad_radix;
    int            item_no;
  } char_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rdse_in_if  num_ch ();
  rdse_out_if char_ch ();

  radix_digit_string_emitter_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_ch),
    .out_o  (char_ch)
  );

  // Characters still owed by the block, oldest first.
  char_result_t expected_chars[$];
  int           error_count;
  int           items_sent;
  // When set, neither side idles at random.
  bit           steady_flow;
  // A nonzero value asks the receiver to hold ready low, for a hold-off whose length is that value.
  int           hold_request;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED_ERRS) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic logic [CW-1:0] ascii_of_digit(input logic [RW-1:0] d);
    logic [CW-1:0] d7;
    d7 = CW'(d);
    if (d < 6'd10) begin
      return rdse_pkg::CHAR_ZERO + d7;
    end else if (d < 6'd36) begin
      return rdse_pkg::CHAR_UPPER_A + d7 - CW'(10);
    end
    return rdse_pkg::CHAR_LOWER_A + d7 - CW'(36);
  endfunction

  // Works out the character string of one number and queues it, most
  // significant digit first.
  function automatic void predict_digit_string(input logic [VW-1:0] value,
                                               input logic [RW-1:0] radix,
                                               input int            item_no);
    logic [63:0]   num;
    logic [63:0]   base;
    logic [RW-1:0] digits[$];
    char_result_t  exp_char;
    // A shift by the full width gives zero, so the mask is all ones at 64 bits.
    num  = value & ((64'd1 << rdse_pkg::VALUE_WIDTH) - 64'd1);
    base = 64'(radix);
    exp_char.item_no = item_no;
    if (radix < rdse_pkg::RADIX_MIN || radix > rdse_pkg::RADIX_MAX) begin
      exp_char.digit_char = rdse_pkg::CHAR_NONE;
      exp_char.last       = 1'b1;
      exp_char.bad_radix  = 1'b1;
      expected_chars.push_back(exp_char);
      return;
    end
    if (num == 64'd0) begin
      exp_char.digit_char = rdse_pkg::CHAR_ZERO;
      exp_char.last       = 1'b1;
      exp_char.bad_radix  = 1'b0;
      expected_chars.push_back(exp_char);
      return;
    end
    while (num != 64'd0) begin
      digits.push_back(RW'(num % base));
      num = num / base;
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      exp_char.digit_char = ascii_of_digit(digits[k]);
      exp_char.last       = (k == 0);
      exp_char.bad_radix  = 1'b0;
      expected_chars.push_back(exp_char);
    end
  endfunction

  // Offers one number and returns at the edge where it is taken. Valid stays
  // high afterwards so that back-to-back items need no second assignment.
  task automatic send_number(input logic [VW-1:0] value, input logic [RW-1:0] radix);
    if (!steady_flow && $urandom_range(99) < 10) begin
      num_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    num_ch.valid <= 1'b1;
    num_ch.value <= value;
    num_ch.radix <= radix;
    do @(posedge clk_i); while (!num_ch.ready);
    predict_digit_string(value, radix, items_sent);
    items_sent++;
  endtask

  // A value with a random number of significant bits, mostly short ones so
  // that base two does not dominate the run time.
  function automatic logic [VW-1:0] random_value();
    logic [VW-1:0] v;
    int            nbits;
    v     = {$urandom, $urandom};
    nbits = ($urandom_range(99) < 20) ? VW : $urandom_range(1, 40);
    if (nbits < VW) begin
      v &= (64'd1 << nbits) - 64'd1;
    end
    return v;
  endfunction

  function automatic logic [RW-1:0] random_radix();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      return RW'(0);
    end else if (pick < 6) begin
      return RW'(1);
    end else if (pick < 9) begin
      return RW'(63);
    end else if (pick < 14) begin
      return rdse_pkg::RADIX_MIN;
    end else if (pick < 19) begin
      return rdse_pkg::RADIX_MAX;
    end
    return RW'($urandom_range(2, 62));
  endfunction

  // Bases 0, 1 and 63 give one flagged result whatever the value.
  task automatic test_bad_radix();
    send_number(64'd0, RW'(0));
    send_number('1, RW'(1));
    send_number(64'd12345, RW'(63));
    send_number(64'h8000_0000_0000_0000, RW'(0));
  endtask

  // Zero gives the single character '0' in any valid base.
  task automatic test_zero_value();
    send_number(64'd0, rdse_pkg::RADIX_MIN);
    send_number(64'd0, RW'(10));
    send_number(64'd0, rdse_pkg::RADIX_MAX);
  endtask

  // Longest strings, single digits at each end of every character range and
  // the first value that needs a second digit.
  task automatic test_digit_extremes();
    send_number('1, rdse_pkg::RADIX_MIN);
    send_number('1, RW'(10));
    send_number('1, RW'(16));
    send_number('1, rdse_pkg::RADIX_MAX);
    send_number(64'd1, rdse_pkg::RADIX_MIN);
    send_number(64'd9, RW'(10));
    send_number(64'd10, RW'(11));
    send_number(64'd35, RW'(36));
    send_number(64'd36, RW'(37));
    send_number(64'd61, rdse_pkg::RADIX_MAX);
    send_number(64'd62, rdse_pkg::RADIX_MAX);
    send_number(64'h5555_5555_5555_5555, RW'(4));
    send_number(64'hAAAA_AAAA_AAAA_AAAA, RW'(32));
  endtask

  // The receiver stops for a long time while numbers keep coming, so the
  // block has to hold its output and then refuse further input.
  task automatic test_output_backpressure();
    hold_request = BACKUP_STALL;
    for (int n = 0; n < 10; n++) begin
      send_number(VW'($urandom_range(0, 4095)), RW'($urandom_range(2, 62)));
    end
  endtask

  // A stretch with both sides always ready, numbers back to back.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_number(random_value(), random_radix());
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_random_numbers();
    logic [VW-1:0] v;
    for (int n = 0; n < 290; n++) begin
      v = ($urandom_range(99) < 5) ? VW'(0) : random_value();
      send_number(v, random_radix());
    end
  endtask

  // Stimulus: reset once, then every test in turn, then drain.
  initial begin
    error_count  = 0;
    items_sent   = 0;
    steady_flow  = 1'b0;
    hold_request = 0;
    rst_ni       <= 1'b0;
    num_ch.valid <= 1'b0;
    num_ch.value <= '0;
    num_ch.radix <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bad_radix();
    test_zero_value();
    test_digit_extremes();
    test_output_backpressure();
    test_back_to_back();
    test_random_numbers();
    num_ch.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stalls, except in steady stretches, plus the long
  // hold-off when a test asks for one.
  initial begin : receiver
    int stall_left;
    char_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
        char_ch.ready <= 1'b0;
        repeat (stall_left - 1) @(posedge clk_i);
      end else begin
        char_ch.ready <= steady_flow || ($urandom_range(99) >= 10);
      end
    end
  end

  // Every character taken is compared with the oldest one still owed.
  always @(posedge clk_i) begin : char_checker
    char_result_t want;
    if (rst_ni && char_ch.valid && char_ch.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%0h with nothing owed", char_ch.digit_char));
      end else begin
        want = expected_chars.pop_front();
        if (char_ch.digit_char !== want.digit_char) begin
          report_mismatch($sformatf("item %0d: digit_char 0x%0h, wanted 0x%0h",
                                    want.item_no, char_ch.digit_char, want.digit_char));
        end
        if (char_ch.last !== want.last) begin
          report_mismatch($sformatf("item %0d: last %b, wanted %b",
                                    want.item_no, char_ch.last, want.last));
        end
        if (char_ch.bad_radix !== want.bad_radix) begin
          report_mismatch($sformatf("item %0d: bad_radix %b, wanted %b",
                                    want.item_no, char_ch.bad_radix, want.bad_radix));
        end
      end
    end
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
